// ===== rtl/npc_pkg.sv =====
// ----------------------------------------------------------------------------
// npc_pkg
// shared widths, codes and lane type of the nearest palette color search
// ----------------------------------------------------------------------------
package npc_pkg;

    localparam int CHAN_W  = 8;
    localparam int COLOR_W = 24;
    localparam int INDEX_W = 5;
    localparam int DIST_W  = 18;
    localparam int COUNT_W = 6;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 6'd32;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_MATCH = 1'b1;

    // distance of one palette entry and whether it takes part in the search
    typedef struct packed {
        logic              en;
        logic [DIST_W-1:0] sq_dist;
    } lane_t;

endpackage

// ===== rtl/npc_lane.sv =====
// ----------------------------------------------------------------------------
// npc_lane
// squared rgb distance of the pixel to one palette entry, two register stages
// ----------------------------------------------------------------------------
module npc_lane
(
    input  logic                                clk,
    input  logic                                adv,
    input  logic                                en,
    input  logic [npc_pkg::CHAN_W-1:0]          red,
    input  logic [npc_pkg::CHAN_W-1:0]          green,
    input  logic [npc_pkg::CHAN_W-1:0]          blue,
    input  logic [npc_pkg::COLOR_W-1:0]         color,
    output npc_pkg::lane_t                      lane
);

    localparam int CW = npc_pkg::CHAN_W;
    localparam int DW = npc_pkg::DIST_W;

    logic [CW-1:0] pr;
    logic [CW-1:0] pg;
    logic [CW-1:0] pb;

    logic [CW-1:0] dr_reg;
    logic [CW-1:0] dg_reg;
    logic [CW-1:0] db_reg;
    logic          en_reg;

    logic [CW-1:0] dr_next;
    logic [CW-1:0] dg_next;
    logic [CW-1:0] db_next;

    logic [DW-1:0] dist_next;
    npc_pkg::lane_t lane_reg;

    assign pr = color[3*CW-1:2*CW];
    assign pg = color[2*CW-1:CW];
    assign pb = color[CW-1:0];

    // absolute channel differences
    assign dr_next = (red   > pr) ? (red   - pr) : (pr - red);
    assign dg_next = (green > pg) ? (green - pg) : (pg - green);
    assign db_next = (blue  > pb) ? (blue  - pb) : (pb - blue);

    assign dist_next = DW'(dr_reg) * DW'(dr_reg)
                     + DW'(dg_reg) * DW'(dg_reg)
                     + DW'(db_reg) * DW'(db_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dr_reg           <= dr_next;
            dg_reg           <= dg_next;
            db_reg           <= db_next;
            en_reg           <= en;
            lane_reg.en      <= en_reg;
            lane_reg.sq_dist <= dist_next;
        end
    end

    assign lane = lane_reg;

endmodule

// ===== rtl/npc_min_tree.sv =====
// ----------------------------------------------------------------------------
// npc_min_tree
// registered minimum tree over the lanes, lower index wins on equal distance
// ----------------------------------------------------------------------------
module npc_min_tree
#(
    parameter int LEAF_N = 32,
    parameter int IDX_W  = 5
)
(
    input  logic                         clk,
    input  logic                         adv,
    input  npc_pkg::lane_t               leaf [LEAF_N],
    output logic [IDX_W-1:0]             root_index,
    output logic [npc_pkg::DIST_W-1:0]   root_dist
);

    localparam int LEVELS = $clog2(LEAF_N);
    localparam int PAD    = 1 << LEVELS;

    typedef struct packed {
        logic                         en;
        logic [IDX_W-1:0]             idx;
        logic [npc_pkg::DIST_W-1:0]   sq_dist;
    } node_t;

    node_t leaf_w   [PAD];
    node_t node_reg [PAD];

    function automatic node_t pick(node_t lo, node_t hi);
        node_t r;
        r = lo;
        if (hi.en && (!lo.en || hi.sq_dist < lo.sq_dist))
        begin
            r = hi;
        end
        return r;
    endfunction

    genvar k;
    generate
        for (k = 0; k < PAD; k++)
        begin : g_leaf
            if (k < LEAF_N)
            begin : g_real
                assign leaf_w[k].en      = leaf[k].en;
                assign leaf_w[k].idx     = IDX_W'(k);
                assign leaf_w[k].sq_dist = leaf[k].sq_dist;
            end
            else
            begin : g_pad
                assign leaf_w[k] = '0;
            end
        end

        // heap order: node k has children 2k and 2k+1, leaves sit at PAD..2*PAD-1
        for (k = 1; k < PAD; k++)
        begin : g_node
            if (2 * k >= PAD)
            begin : g_bottom
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        node_reg[k] <= pick(leaf_w[2*k-PAD], leaf_w[2*k+1-PAD]);
                    end
                end
            end
            else
            begin : g_inner
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        node_reg[k] <= pick(node_reg[2*k], node_reg[2*k+1]);
                    end
                end
            end
        end

        if (PAD == 1)
        begin : g_single
            assign root_index = leaf_w[0].idx;
            assign root_dist  = leaf_w[0].sq_dist;
        end
        else
        begin : g_root
            assign root_index = node_reg[1].idx;
            assign root_dist  = node_reg[1].sq_dist;
        end
    endgenerate

endmodule

// ===== rtl/nearest_palette_color.sv =====
// ----------------------------------------------------------------------------
// nearest_palette_color
// nearest palette entry to an rgb pixel by squared euclidean distance
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake                payload
//   cfg       in          cfg_valid / cfg_ready    cfg_data (palette_count)
//   in        in          in_valid / in_ready      func, entry_index, entry_color,
//                                                  red, green, blue
//   out       out         out_valid / out_ready    best_index, best_distance
//
// one request per cycle while the output does not stall; a match result passes
// through two lane stages, the minimum tree and the output register. a load
// writes its palette register at acceptance.
// the whole pipeline holds while a result waits on out_ready.
// reset clears the valid bits and sets palette_count to 32; palette entries
// hold nothing defined until loaded.
// ----------------------------------------------------------------------------
module nearest_palette_color
#(
    parameter int PALETTE_DEPTH = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [npc_pkg::COUNT_W-1:0]         cfg_data,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                func,
    input  logic [npc_pkg::INDEX_W-1:0]         entry_index,
    input  logic [npc_pkg::COLOR_W-1:0]         entry_color,
    input  logic [npc_pkg::CHAN_W-1:0]          red,
    input  logic [npc_pkg::CHAN_W-1:0]          green,
    input  logic [npc_pkg::CHAN_W-1:0]          blue,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [npc_pkg::INDEX_W-1:0]         best_index,
    output logic [npc_pkg::DIST_W-1:0]          best_distance
);

    localparam int LEVELS = $clog2(PALETTE_DEPTH);
    localparam int IDX_W  = (LEVELS > 0) ? LEVELS : 1;
    localparam int VLAT   = LEVELS + 2;
    localparam int IW     = npc_pkg::INDEX_W;

    logic                          adv;
    logic                          in_fire;
    logic                          load_fire;
    logic                          match_fire;

    logic [npc_pkg::COUNT_W-1:0]   palette_count_reg;
    logic [npc_pkg::COLOR_W-1:0]   palette_reg [PALETTE_DEPTH];
    logic [PALETTE_DEPTH-1:0]      lane_en;
    npc_pkg::lane_t                lane [PALETTE_DEPTH];

    logic [VLAT-1:0]               vpipe_reg;
    logic [VLAT-1:0]               vpipe_next;

    logic [IDX_W-1:0]              root_index;
    logic [npc_pkg::DIST_W-1:0]    root_dist;

    logic                          out_valid_reg;
    logic [IW-1:0]                 best_index_reg;
    logic [npc_pkg::DIST_W-1:0]    best_distance_reg;

    assign adv        = !out_valid_reg || out_ready;
    assign in_ready   = adv;
    assign in_fire    = in_valid && in_ready;
    assign load_fire  = in_fire && (func == npc_pkg::FUNC_LOAD);
    assign match_fire = in_fire && (func == npc_pkg::FUNC_MATCH);
    assign cfg_ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_count_reg <= npc_pkg::COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            palette_count_reg <= cfg_data;
        end
    end

    genvar i;
    generate
        for (i = 0; i < PALETTE_DEPTH; i++)
        begin : g_entry
            always_ff @(posedge clk)
            begin
                if (load_fire && (int'(entry_index) == i))
                begin
                    palette_reg[i] <= entry_color;
                end
            end

            // count of zero still searches entry 0, counts past the depth saturate
            assign lane_en[i] = (i == 0) || (i < int'(palette_count_reg));

            npc_lane u_lane
            (
                .clk   (clk),
                .adv   (adv),
                .en    (lane_en[i]),
                .red   (red),
                .green (green),
                .blue  (blue),
                .color (palette_reg[i]),
                .lane  (lane[i])
            );
        end
    endgenerate

    npc_min_tree
    #(
        .LEAF_N (PALETTE_DEPTH),
        .IDX_W  (IDX_W)
    )
    u_tree
    (
        .clk        (clk),
        .adv        (adv),
        .leaf       (lane),
        .root_index (root_index),
        .root_dist  (root_dist)
    );

    generate
        if (VLAT > 1)
        begin : g_vshift
            assign vpipe_next = {vpipe_reg[VLAT-2:0], match_fire};
        end
        else
        begin : g_vone
            assign vpipe_next = match_fire;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vpipe_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vpipe_reg     <= vpipe_next;
            out_valid_reg <= vpipe_reg[VLAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            best_index_reg    <= IW'(root_index);
            best_distance_reg <= root_dist;
        end
    end

    assign out_valid     = out_valid_reg;
    assign best_index    = best_index_reg;
    assign best_distance = best_distance_reg;

    // a load never enters the result pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        load_fire |=> !vpipe_reg[0])
        else $error("load request entered result pipeline");

    // every match enters the result pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        match_fire |=> vpipe_reg[0])
        else $error("match request lost at entry");

    // a stall freezes the in-flight valid bits
    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vpipe_reg) && out_valid_reg)
        else $error("pipeline moved during stall");

endmodule
